// ----- src/mtcs_pkg.sv -----
// Shared types and constants for the missing-tooth crank synchronizer.
package mtcs_pkg;

    typedef enum logic [1:0] {
        OP_TOOTH   = 2'd0,
        OP_CAM     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    localparam logic [2:0] MODE_LOST    = 3'd0;
    localparam logic [2:0] MODE_SEEK    = 3'd1;
    localparam logic [2:0] MODE_CONFIRM = 3'd2;
    localparam logic [2:0] MODE_CRANK   = 3'd3;
    localparam logic [2:0] MODE_CAM     = 3'd4;
    localparam logic [2:0] MODE_FULL    = 3'd5;

    localparam logic [1:0] REASON_TIMEOUT = 2'd1;
    localparam logic [1:0] REASON_BAD_GAP = 2'd2;
    localparam logic [1:0] REASON_COUNT   = 2'd3;

    localparam logic [2:0] CFG_MIN_PERIOD = 3'd0;
    localparam logic [2:0] CFG_MAX_PERIOD = 3'd1;
    localparam logic [2:0] CFG_RATIO_LOW  = 3'd2;
    localparam logic [2:0] CFG_RATIO_HIGH = 3'd3;
    localparam logic [2:0] CFG_TRIGGER    = 3'd4;
    localparam logic [2:0] CFG_STALL      = 3'd5;
    localparam logic [2:0] CFG_RPM_STEP   = 3'd6;
    localparam logic [2:0] CFG_COOLDOWN   = 3'd7;

    localparam logic [25:0] RPM_NUMERATOR = 26'd60000000;
    localparam int DIV_STEPS = 26;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture the event and start the divider
        logic div_step;  // advance the divider by one bit
        logic finish;    // commit the event's state update
    } mtcs_cmd_t;

    typedef struct packed {
        logic div_done;
    } mtcs_status_t;

endpackage

// ----- src/mtcs_ctrl.sv -----
// Controller: sequences load, divider steps and commit for each event.
module mtcs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mtcs_pkg::mtcs_cmd_t   cmd,
    input  mtcs_pkg::mtcs_status_t status
);
    import mtcs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_OUTPUT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/mtcs_datapath.sv -----
// Datapath: configuration, sync state, gap ratio, rpm divider and counters.
module mtcs_datapath #(
    parameter int WHEEL_TEETH     = 60,
    parameter int GAP_TEETH       = 2,
    parameter int STEP_DEGREES    = 6,
    parameter int GAPS_TO_LOCK    = 2,
    parameter int BAD_TOOTH_LIMIT = 3,
    parameter int RPM_CEILING     = 10000
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic [1:0]             opcode,
    input  logic [31:0]            timestamp_us,
    input  mtcs_pkg::mtcs_cmd_t    cmd,
    output mtcs_pkg::mtcs_status_t status,
    output logic [2:0]             sync_state,
    output logic                   sync_valid,
    output logic [9:0]             crank_angle,
    output logic [15:0]            engine_rpm,
    output logic [15:0]            smoothed_rpm,
    output logic                   compression_phase,
    output logic                   cycle_wrapped,
    output logic [1:0]             loss_reason,
    output logic [15:0]            loss_total,
    output logic [15:0]            noise_total,
    output logic [15:0]            resync_total,
    output logic [15:0]            gap_ratio_q8
);
    import mtcs_pkg::*;

    localparam int EXPECTED = WHEEL_TEETH - GAP_TEETH;

    logic [15:0] min_period_reg;
    logic [31:0] max_period_reg, stall_reg, cooldown_reg;
    logic [11:0] ratio_low_reg, ratio_high_reg;
    logic [8:0]  trigger_reg;
    logic [15:0] rpm_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= 16'd50;
            max_period_reg <= 32'd100000;
            ratio_low_reg  <= 12'd384;
            ratio_high_reg <= 12'd896;
            trigger_reg    <= 9'd0;
            stall_reg      <= 32'd500000;
            rpm_step_reg   <= 16'd1000;
            cooldown_reg   <= 32'd100000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_PERIOD: min_period_reg <= cfg_data[15:0];
                CFG_MAX_PERIOD: max_period_reg <= cfg_data;
                CFG_RATIO_LOW:  ratio_low_reg  <= cfg_data[11:0];
                CFG_RATIO_HIGH: ratio_high_reg <= cfg_data[11:0];
                CFG_TRIGGER:    trigger_reg    <= cfg_data[8:0];
                CFG_STALL:      stall_reg      <= cfg_data;
                CFG_RPM_STEP:   rpm_step_reg   <= cfg_data[15:0];
                CFG_COOLDOWN:   cooldown_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sync state.
    logic [2:0]  mode_reg;
    logic [7:0]  tag_reg, tooth_reg, bad_reg;
    logic [9:0]  angle_reg;
    logic [2:0]  gaps_reg;
    logic        cam_reg, phase_reg, pend_reg, wrap_reg;
    logic [31:0] last_edge_reg, period_now_reg, period_before_reg, period_avg_reg;
    logic [31:0] last_rec_reg;
    logic [15:0] rpm_reg, smooth_reg, loss_reg, noise_reg, resync_reg, ratio_reg;
    logic [1:0]  reason_reg;

    // Captured event and divider.
    logic [1:0]  op_reg;
    logic [31:0] ts_reg;
    logic [31:0] elapsed_reg;
    logic [39:0] num_reg;
    logic [39:0] rem_reg;      // ratio division remainder
    logic [39:0] quo_reg;
    logic [5:0]  ratio_cnt_reg;
    logic [25:0] rnum_reg;
    logic [38:0] rrem_reg;
    logic [25:0] rquo_reg;
    logic [38:0] rdiv_reg;
    logic [44:0] low_prod_reg, high_prod_reg;
    logic [44:0] ratio_mul_a_next, ratio_mul_b_next;

    logic [31:0] elapsed_c;
    assign elapsed_c = ts_reg - last_edge_reg;

    // Ratio divider runs 40 bits; rpm divider 26 bits in the same window.
    logic [40:0] rtrial;
    logic [39:0] rshift;
    logic [39:0] pshift;
    logic [39:0] ptrial;
    always_comb
    begin
        rshift = {rem_reg[38:0], num_reg[39]};
        rtrial = {1'b0, rshift} - {9'd0, period_now_reg};
        pshift = {rrem_reg, rnum_reg[25]};
        ptrial = pshift - {1'b0, rdiv_reg};
    end

    assign ratio_mul_a_next = {33'd0, ratio_low_reg} * {13'd0, period_now_reg};
    assign ratio_mul_b_next = {33'd0, ratio_high_reg} * {13'd0, period_now_reg};
    assign status.div_done = (ratio_cnt_reg == 6'd41);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ratio_cnt_reg <= '0;
        else if (cmd.load)
            ratio_cnt_reg <= '0;
        else if (cmd.div_step && ratio_cnt_reg != 6'd41)
            ratio_cnt_reg <= ratio_cnt_reg + 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            ts_reg <= timestamp_us;
        end
        else if (cmd.div_step)
        begin
            if (ratio_cnt_reg == 6'd0)
            begin
                elapsed_reg   <= elapsed_c;
                num_reg       <= {elapsed_c, 8'd0};
                rem_reg       <= '0;
                quo_reg       <= '0;
                rnum_reg      <= RPM_NUMERATOR;
                rrem_reg      <= '0;
                rquo_reg      <= '0;
                rdiv_reg      <= elapsed_c * 39'(EXPECTED);
                low_prod_reg  <= ratio_mul_a_next;
                high_prod_reg <= ratio_mul_b_next;
            end
            else if (ratio_cnt_reg != 6'd41)
            begin
                num_reg <= {num_reg[38:0], 1'b0};
                if (period_now_reg != 32'd0 && !rtrial[40])
                begin
                    rem_reg <= rtrial[39:0];
                    quo_reg <= {quo_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rshift;
                    quo_reg <= {quo_reg[38:0], 1'b0};
                end
                if (ratio_cnt_reg <= 6'(DIV_STEPS))
                begin
                    rnum_reg <= {rnum_reg[24:0], 1'b0};
                    if (pshift >= {1'b0, rdiv_reg})
                    begin
                        rrem_reg <= ptrial[38:0];
                        rquo_reg <= {rquo_reg[24:0], 1'b1};
                    end
                    else
                    begin
                        rrem_reg <= pshift[38:0];
                        rquo_reg <= {rquo_reg[24:0], 1'b0};
                    end
                end
            end
        end
    end

    function automatic logic [7:0] sat8(input logic [7:0] v);
        sat8 = (v == 8'hFF) ? v : v + 8'd1;
    endfunction
    function automatic logic [15:0] sat16(input logic [15:0] v);
        sat16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    logic [9:0] trig;
    assign trig = (trigger_reg >= 9'd360) ? 10'(trigger_reg - 9'd360) : {1'b0, trigger_reg};

    // Commit logic.
    logic [2:0]  m_n;
    logic [7:0]  tag_n, tooth_n, bad_n;
    logic [9:0]  ang_n;
    logic [10:0] ang_w;
    logic [2:0]  gaps_n;
    logic        cam_n, phase_n, pend_n, wrap_n;
    logic [31:0] le_n, pn_n, pb_n, pa_n, lr_n;
    logic [15:0] rpm_n, sm_n, loss_n, noise_n, resync_n, ratio_n;
    logic [1:0]  reason_n;
    logic        gap, drop, early;
    logic [1:0]  why;
    logic [15:0] nr, dlt;
    logic [33:0] pa_sum;
    logic [18:0] sm_sum;
    logic [39:0] n40;

    always_comb
    begin
        m_n = mode_reg; tag_n = tag_reg; tooth_n = tooth_reg; bad_n = bad_reg;
        ang_n = angle_reg; gaps_n = gaps_reg; cam_n = cam_reg; phase_n = phase_reg;
        pend_n = pend_reg; wrap_n = wrap_reg; le_n = last_edge_reg;
        pn_n = period_now_reg; pb_n = period_before_reg; pa_n = period_avg_reg;
        lr_n = last_rec_reg; rpm_n = rpm_reg; sm_n = smooth_reg; loss_n = loss_reg;
        noise_n = noise_reg; resync_n = resync_reg; ratio_n = ratio_reg;
        reason_n = reason_reg;
        gap = 1'b0; drop = 1'b0; why = '0; early = 1'b0;
        nr = '0; dlt = '0; pa_sum = '0; sm_sum = '0; ang_w = '0;
        n40 = {elapsed_reg, 8'd0};
        case (op_reg)
            OP_TOOTH:
            begin
                if (elapsed_reg < {16'd0, min_period_reg})
                begin
                    noise_n = sat16(noise_reg);
                    early = 1'b1;
                end
                else if (elapsed_reg > max_period_reg && mode_reg >= MODE_CRANK)
                begin
                    loss_n = sat16(loss_reg); reason_n = REASON_TIMEOUT;
                    cam_n = 1'b0; m_n = MODE_SEEK; gaps_n = '0; tooth_n = '0; tag_n = '0;
                    le_n = ts_reg; pn_n = elapsed_reg;
                    early = 1'b1;
                end
                if (!early)
                begin
                    if (period_now_reg != 32'd0)
                    begin
                        ratio_n = (quo_reg > 40'd65535) ? 16'hFFFF : quo_reg[15:0];
                        gap = ({5'd0, n40} >= low_prod_reg) && ({5'd0, n40} <= high_prod_reg);
                    end
                    unique case (mode_reg)
                        MODE_LOST:
                        begin
                            m_n = MODE_SEEK; tag_n = '0; gaps_n = '0;
                        end
                        MODE_SEEK:
                        begin
                            if (gap)
                            begin
                                m_n = MODE_CONFIRM; gaps_n = 3'd1; tooth_n = 8'd1;
                                tag_n = '0; ang_n = trig;
                            end
                        end
                        MODE_CONFIRM:
                        begin
                            tag_n = sat8(tag_reg); tooth_n = sat8(tooth_reg);
                            ang_w = {1'b0, angle_reg} + 11'(STEP_DEGREES);
                            ang_n = (ang_w >= 11'd360) ? 10'(ang_w - 11'd360) : ang_w[9:0];
                            if (gap)
                            begin
                                if (tag_n == 8'(EXPECTED))
                                begin
                                    gaps_n = (gaps_reg == 3'd7) ? gaps_reg : gaps_reg + 3'd1;
                                    if (gaps_n >= 3'(GAPS_TO_LOCK))
                                    begin
                                        m_n = MODE_CRANK; bad_n = '0;
                                        if (pend_reg)
                                        begin
                                            resync_n = sat16(resync_reg); pend_n = 1'b0;
                                        end
                                    end
                                    tooth_n = 8'd1; tag_n = '0; ang_n = trig;
                                end
                                else
                                begin
                                    m_n = MODE_SEEK; gaps_n = '0; tag_n = '0;
                                end
                            end
                        end
                        MODE_CRANK, MODE_CAM, MODE_FULL:
                        begin
                            tag_n = sat8(tag_reg); tooth_n = sat8(tooth_reg);
                            ang_w = {1'b0, angle_reg} + 11'(STEP_DEGREES);
                            if (ang_w >= 11'd720)
                            begin
                                ang_w = ang_w - 11'd720; wrap_n = 1'b1;
                            end
                            ang_n = ang_w[9:0];
                            if (gap)
                            begin
                                if (tag_n == 8'(EXPECTED))
                                begin
                                    tooth_n = 8'd1; tag_n = '0;
                                    ang_n = (cam_reg && ang_n >= 10'd360) ? trig + 10'd360 : trig;
                                    bad_n = '0;
                                end
                                else if ({1'b0, tag_n} < 9'(EXPECTED - 2)
                                    || {1'b0, tag_n} > 9'(EXPECTED + 2))
                                begin
                                    bad_n = sat8(bad_n);
                                    if (bad_n >= 8'(BAD_TOOTH_LIMIT))
                                    begin
                                        drop = 1'b1; why = REASON_BAD_GAP;
                                    end
                                end
                            end
                            if (drop)
                            begin
                                loss_n = sat16(loss_n); reason_n = why; cam_n = 1'b0;
                                m_n = MODE_SEEK; gaps_n = '0; tooth_n = '0; tag_n = '0;
                                if (ts_reg - lr_n >= cooldown_reg)
                                begin
                                    lr_n = ts_reg; pend_n = 1'b1; bad_n = '0;
                                end
                            end
                            if ({1'b0, tag_n} > 9'(EXPECTED + 3))
                            begin
                                bad_n = sat8(bad_n);
                                if (bad_n >= 8'(BAD_TOOTH_LIMIT))
                                begin
                                    loss_n = sat16(loss_n); reason_n = REASON_COUNT;
                                    cam_n = 1'b0; m_n = MODE_SEEK; gaps_n = '0;
                                    tooth_n = '0; tag_n = '0;
                                    if (ts_reg - lr_n >= cooldown_reg)
                                    begin
                                        lr_n = ts_reg; pend_n = 1'b1; bad_n = '0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (elapsed_reg != 32'd0 && m_n >= MODE_CRANK && m_n <= MODE_FULL
                        && rquo_reg != 26'd0 && rquo_reg < 26'(RPM_CEILING))
                    begin
                        nr = rquo_reg[15:0];
                        if (rpm_reg != 16'd0)
                        begin
                            dlt = (nr > rpm_reg) ? nr - rpm_reg : rpm_reg - nr;
                            if (dlt > rpm_step_reg && rpm_reg > 16'd500)
                                bad_n = sat8(bad_n);
                            else
                            begin
                                bad_n = '0; rpm_n = nr;
                            end
                        end
                        else
                            rpm_n = nr;
                        sm_sum = {3'd0, smooth_reg} * 19'd7 + {3'd0, rpm_n};
                        sm_n = sm_sum[18:3];
                    end
                    pb_n = period_now_reg; pn_n = elapsed_reg; le_n = ts_reg;
                    pa_sum = {2'd0, period_avg_reg} * 34'd3 + {2'd0, elapsed_reg};
                    pa_n = pa_sum[33:2];
                end
            end
            OP_CAM:
            begin
                if (mode_reg >= MODE_CRANK && mode_reg <= MODE_FULL)
                begin
                    if (!cam_reg)
                    begin
                        cam_n = 1'b1; phase_n = 1'b1;
                        if (angle_reg < 10'd360)
                            ang_n = angle_reg + 10'd360;
                        if (mode_reg == MODE_CRANK)
                            m_n = MODE_CAM;
                    end
                    else
                        phase_n = ~phase_reg;
                    if (m_n == MODE_CAM)
                        m_n = MODE_FULL;
                end
            end
            OP_TIMEOUT:
            begin
                if (mode_reg >= MODE_CRANK && mode_reg <= MODE_FULL
                    && (ts_reg - last_edge_reg) > stall_reg)
                begin
                    loss_n = sat16(loss_reg); reason_n = REASON_TIMEOUT;
                    cam_n = 1'b0; m_n = MODE_SEEK; gaps_n = '0; tooth_n = '0; tag_n = '0;
                    rpm_n = '0; sm_n = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LOST; tag_reg <= '0; tooth_reg <= '0; bad_reg <= '0;
            angle_reg <= '0; gaps_reg <= '0; cam_reg <= 1'b0; phase_reg <= 1'b0;
            pend_reg <= 1'b0; wrap_reg <= 1'b0; last_edge_reg <= '0;
            period_now_reg <= '0; period_before_reg <= '0; period_avg_reg <= '0;
            last_rec_reg <= '0; rpm_reg <= '0; smooth_reg <= '0; loss_reg <= '0;
            noise_reg <= '0; resync_reg <= '0; ratio_reg <= '0; reason_reg <= '0;
        end
        else if (cmd.finish)
        begin
            mode_reg <= m_n; tag_reg <= tag_n; tooth_reg <= tooth_n; bad_reg <= bad_n;
            angle_reg <= ang_n; gaps_reg <= gaps_n; cam_reg <= cam_n; phase_reg <= phase_n;
            pend_reg <= pend_n; wrap_reg <= wrap_n; last_edge_reg <= le_n;
            period_now_reg <= pn_n; period_before_reg <= pb_n; period_avg_reg <= pa_n;
            last_rec_reg <= lr_n; rpm_reg <= rpm_n; smooth_reg <= sm_n; loss_reg <= loss_n;
            noise_reg <= noise_n; resync_reg <= resync_n; ratio_reg <= ratio_n;
            reason_reg <= reason_n;
        end
    end

    assign sync_state        = mode_reg;
    assign sync_valid        = (mode_reg >= MODE_CRANK) && (mode_reg <= MODE_FULL);
    assign crank_angle       = angle_reg;
    assign engine_rpm        = rpm_reg;
    assign smoothed_rpm      = smooth_reg;
    assign compression_phase = phase_reg;
    assign cycle_wrapped     = wrap_reg;
    assign loss_reason       = reason_reg;
    assign loss_total        = loss_reg;
    assign noise_total       = noise_reg;
    assign resync_total      = resync_reg;
    assign gap_ratio_q8      = ratio_reg;

endmodule

// ----- src/missing_tooth_crank_sync_top.sv -----
// Top level of the missing-tooth crank synchronizer.
// An event is captured on input transfer, then passes the divide and commit states before the result is valid.
// A new event is taken only after the previous result transfers; the bit-serial ratio and rpm dividers serve one event.
// The result holds in the output register until its transfer completes.
// Reset (rst_n low, asynchronous) restores default configuration and lost sync.
module missing_tooth_crank_sync_top #(
    parameter int WHEEL_TEETH     = 60,
    parameter int GAP_TEETH       = 2,
    parameter int STEP_DEGREES    = 6,
    parameter int GAPS_TO_LOCK    = 2,
    parameter int BAD_TOOTH_LIMIT = 3,
    parameter int RPM_CEILING     = 10000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] timestamp_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  sync_state,
    output logic        sync_valid,
    output logic [9:0]  crank_angle,
    output logic [15:0] engine_rpm,
    output logic [15:0] smoothed_rpm,
    output logic        compression_phase,
    output logic        cycle_wrapped,
    output logic [1:0]  loss_reason,
    output logic [15:0] loss_total,
    output logic [15:0] noise_total,
    output logic [15:0] resync_total,
    output logic [15:0] gap_ratio_q8
);
    import mtcs_pkg::*;

    mtcs_cmd_t    cmd;
    mtcs_status_t status;

    assign cfg_ready = 1'b1;

    mtcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
    );

    mtcs_datapath #(
        .WHEEL_TEETH(WHEEL_TEETH), .GAP_TEETH(GAP_TEETH), .STEP_DEGREES(STEP_DEGREES),
        .GAPS_TO_LOCK(GAPS_TO_LOCK), .BAD_TOOTH_LIMIT(BAD_TOOTH_LIMIT),
        .RPM_CEILING(RPM_CEILING)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .opcode(opcode), .timestamp_us(timestamp_us),
        .cmd(cmd), .status(status), .sync_state(sync_state), .sync_valid(sync_valid),
        .crank_angle(crank_angle), .engine_rpm(engine_rpm), .smoothed_rpm(smoothed_rpm),
        .compression_phase(compression_phase), .cycle_wrapped(cycle_wrapped),
        .loss_reason(loss_reason), .loss_total(loss_total), .noise_total(noise_total),
        .resync_total(resync_total), .gap_ratio_q8(gap_ratio_q8)
    );

endmodule

// ----- src/mtcs_checker.sv -----
// Port-level checker for the crank synchronizer, bound to the top level.
module mtcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  sync_state,
    input logic        sync_valid,
    input logic [9:0]  crank_angle,
    input logic [15:0] loss_total
);
    import mtcs_pkg::*;

    property p_result_holds;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sync_state) && $stable(crank_angle);
    endproperty
    a_result_holds: assert property (p_result_holds) else $error("result changed while stalled");

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("input taken while busy");

    property p_valid_flag;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> sync_valid == (sync_state == MODE_CRANK || sync_state == MODE_CAM
            || sync_state == MODE_FULL);
    endproperty
    a_valid_flag: assert property (p_valid_flag) else $error("sync_valid mismatch");

    property p_angle_range;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> crank_angle < 10'd720;
    endproperty
    a_angle_range: assert property (p_angle_range) else $error("angle out of range");

    property p_loss_monotone;
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> loss_total >= $past(loss_total);
    endproperty
    a_loss_monotone: assert property (p_loss_monotone) else $error("loss count decreased");

endmodule

bind missing_tooth_crank_sync_top mtcs_checker u_mtcs_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sync_state(sync_state),
    .sync_valid(sync_valid), .crank_angle(crank_angle), .loss_total(loss_total)
);

// ----- tb/missing_tooth_crank_sync_checker.sv -----
// Checker for the crank synchronizer: predicts every result and compares it.
module missing_tooth_crank_sync_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] timestamp_us,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  sync_state,
    input  logic        sync_valid,
    input  logic [9:0]  crank_angle,
    input  logic [15:0] engine_rpm,
    input  logic [15:0] smoothed_rpm,
    input  logic        compression_phase,
    input  logic        cycle_wrapped,
    input  logic [1:0]  loss_reason,
    input  logic [15:0] loss_total,
    input  logic [15:0] noise_total,
    input  logic [15:0] resync_total,
    input  logic [15:0] gap_ratio_q8,
    output int          errors,
    output int          pending,
    output int          checked
);
    import mtcs_pkg::*;

    localparam int EXPECTED_TEETH  = 58;
    localparam int STEP_DEGREES    = 6;
    localparam int GAPS_TO_LOCK    = 2;
    localparam int BAD_TOOTH_LIMIT = 3;
    localparam int RPM_CEILING     = 10000;

    typedef struct packed {
        logic [2:0]  state;
        logic        locked;
        logic [9:0]  angle;
        logic [15:0] rpm;
        logic [15:0] rpm_avg;
        logic        phase;
        logic        wrapped;
        logic [1:0]  reason;
        logic [15:0] losses;
        logic [15:0] noise;
        logic [15:0] resyncs;
        logic [15:0] ratio;
    } sync_result_t;

    sync_result_t sync_results_q[$];

    // configuration copy
    logic [15:0] min_period;
    logic [31:0] max_period;
    logic [11:0] ratio_lo, ratio_hi;
    logic [8:0]  trigger_deg;
    logic [31:0] stall_limit;
    logic [15:0] rpm_step;
    logic [31:0] cooldown;

    // decoder state copy
    logic [2:0]  mode;
    logic [7:0]  since_gap, tooth_idx, bad_cnt;
    logic [9:0]  angle;
    logic [2:0]  gap_cnt;
    logic        cam_lock, phase, recover_wait, wrap;
    logic [31:0] last_edge, period_cur, period_prev, period_avg, last_recover;
    logic [15:0] rpm, rpm_avg, loss_cnt, noise_cnt, resync_cnt, ratio;
    logic [1:0]  reason;

    assign pending = sync_results_q.size();

    function automatic logic [15:0] bump16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [7:0] bump8(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [9:0] trigger_angle();
        return (trigger_deg >= 9'd360) ? 10'(trigger_deg - 9'd360) : 10'(trigger_deg);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic lose_sync(logic [1:0] why);
        loss_cnt  = bump16(loss_cnt);
        reason    = why;
        cam_lock  = 1'b0;
        mode      = MODE_SEEK;
        gap_cnt   = 3'd0;
        tooth_idx = 8'd0;
        since_gap = 8'd0;
    endtask

    task automatic attempt_recovery(logic [31:0] now);
        if (now - last_recover < cooldown)
            return;
        last_recover = now;
        recover_wait = 1'b1;
        mode         = MODE_SEEK;
        gap_cnt      = 3'd0;
        bad_cnt      = 8'd0;
        since_gap    = 8'd0;
        cam_lock     = 1'b0;
    endtask

    task automatic tooth_edge(logic [31:0] ts);
        logic [31:0] elapsed;
        logic [63:0] num, quo, divisor, rate;
        logic [15:0] new_rpm, delta;
        logic        gap;
        int          t;
        elapsed = ts - last_edge;
        gap = 1'b0;
        if (elapsed < 32'(min_period)) begin
            noise_cnt = bump16(noise_cnt);
            return;
        end
        if (elapsed > max_period && mode >= MODE_CRANK) begin
            lose_sync(REASON_TIMEOUT);
            last_edge  = ts;
            period_cur = elapsed;
            return;
        end
        if (period_cur != 0) begin
            num   = {24'd0, elapsed, 8'd0};
            quo   = num / period_cur;
            ratio = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
            gap   = (num >= 64'(ratio_lo) * period_cur) && (num <= 64'(ratio_hi) * period_cur);
        end

        if (mode == MODE_LOST) begin
            mode      = MODE_SEEK;
            since_gap = 8'd0;
            gap_cnt   = 3'd0;
        end else if (mode == MODE_SEEK) begin
            if (gap) begin
                mode      = MODE_CONFIRM;
                gap_cnt   = 3'd1;
                tooth_idx = 8'd1;
                since_gap = 8'd0;
                angle     = trigger_angle();
            end
        end else if (mode == MODE_CONFIRM) begin
            since_gap = bump8(since_gap);
            tooth_idx = bump8(tooth_idx);
            angle     = (angle + STEP_DEGREES) % 360;
            if (gap) begin
                if (since_gap == EXPECTED_TEETH) begin
                    gap_cnt = (gap_cnt < 3'd7) ? gap_cnt + 3'd1 : 3'd7;
                    if (gap_cnt >= GAPS_TO_LOCK) begin
                        mode    = MODE_CRANK;
                        bad_cnt = 8'd0;
                        if (recover_wait) begin
                            resync_cnt   = bump16(resync_cnt);
                            recover_wait = 1'b0;
                        end
                    end
                    tooth_idx = 8'd1;
                    since_gap = 8'd0;
                    angle     = trigger_angle();
                end else begin
                    mode      = MODE_SEEK;
                    gap_cnt   = 3'd0;
                    since_gap = 8'd0;
                end
            end
        end else if (mode <= MODE_FULL) begin
            since_gap = bump8(since_gap);
            tooth_idx = bump8(tooth_idx);
            angle     = angle + STEP_DEGREES;
            if (angle >= 10'd720) begin
                angle = angle - 10'd720;
                wrap  = 1'b1;
            end
            if (gap) begin
                t = since_gap;
                if (t == EXPECTED_TEETH) begin
                    tooth_idx = 8'd1;
                    since_gap = 8'd0;
                    angle = (cam_lock && angle >= 10'd360) ? trigger_angle() + 10'd360
                                                           : trigger_angle();
                    bad_cnt = 8'd0;
                end else if (t < EXPECTED_TEETH - 2 || t > EXPECTED_TEETH + 2) begin
                    bad_cnt = bump8(bad_cnt);
                    if (bad_cnt >= BAD_TOOTH_LIMIT) begin
                        lose_sync(REASON_BAD_GAP);
                        attempt_recovery(ts);
                    end
                end
            end
            if (int'(since_gap) > EXPECTED_TEETH + 3) begin
                bad_cnt = bump8(bad_cnt);
                if (bad_cnt >= BAD_TOOTH_LIMIT) begin
                    lose_sync(REASON_COUNT);
                    attempt_recovery(ts);
                end
            end
        end

        if (elapsed > 0 && mode >= MODE_CRANK) begin
            divisor = 64'(elapsed) * EXPECTED_TEETH;
            rate    = 64'd60000000 / divisor;
            if (rate > 0 && rate < RPM_CEILING) begin
                new_rpm = rate[15:0];
                if (rpm > 0) begin
                    delta = (new_rpm > rpm) ? new_rpm - rpm : rpm - new_rpm;
                    if (delta > rpm_step && rpm > 16'd500) begin
                        bad_cnt = bump8(bad_cnt);
                    end else begin
                        bad_cnt = 8'd0;
                        rpm     = new_rpm;
                    end
                end else begin
                    rpm = new_rpm;
                end
                rpm_avg = 16'((32'(rpm_avg) * 7 + 32'(rpm)) / 8);
            end
        end

        period_prev = period_cur;
        period_cur  = elapsed;
        last_edge   = ts;
        period_avg  = 32'((64'(period_avg) * 3 + 64'(elapsed)) / 4);
    endtask

    task automatic cam_edge();
        if (mode < MODE_CRANK || mode > MODE_FULL)
            return;
        if (!cam_lock) begin
            cam_lock = 1'b1;
            phase    = 1'b1;
            if (angle < 10'd360)
                angle = angle + 10'd360;
            if (mode == MODE_CRANK)
                mode = MODE_CAM;
        end else begin
            phase = ~phase;
        end
        if (mode == MODE_CAM && cam_lock)
            mode = MODE_FULL;
    endtask

    task automatic stall_check(logic [31:0] ts);
        if (mode >= MODE_CRANK && mode <= MODE_FULL && ts - last_edge > stall_limit) begin
            lose_sync(REASON_TIMEOUT);
            rpm     = 16'd0;
            rpm_avg = 16'd0;
        end
    endtask

    task automatic predict_event(logic [1:0] op, logic [31:0] ts);
        sync_result_t r;
        case (op)
            OP_TOOTH:   tooth_edge(ts);
            OP_CAM:     cam_edge();
            OP_TIMEOUT: stall_check(ts);
            default:    ;
        endcase
        r.state   = mode;
        r.locked  = (mode >= MODE_CRANK && mode <= MODE_FULL);
        r.angle   = angle;
        r.rpm     = rpm;
        r.rpm_avg = rpm_avg;
        r.phase   = phase;
        r.wrapped = wrap;
        r.reason  = reason;
        r.losses  = loss_cnt;
        r.noise   = noise_cnt;
        r.resyncs = resync_cnt;
        r.ratio   = ratio;
        sync_results_q.push_back(r);
    endtask

    task automatic compare_result();
        sync_result_t w;
        if (sync_results_q.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
        end
        w = sync_results_q.pop_front();
        checked++;
        if (sync_state != w.state)          report("sync_state", sync_state, w.state);
        if (sync_valid != w.locked)         report("sync_valid", sync_valid, w.locked);
        if (crank_angle != w.angle)         report("crank_angle", crank_angle, w.angle);
        if (engine_rpm != w.rpm)            report("engine_rpm", engine_rpm, w.rpm);
        if (smoothed_rpm != w.rpm_avg)      report("smoothed_rpm", smoothed_rpm, w.rpm_avg);
        if (compression_phase != w.phase)   report("compression_phase", compression_phase, w.phase);
        if (cycle_wrapped != w.wrapped)     report("cycle_wrapped", cycle_wrapped, w.wrapped);
        if (loss_reason != w.reason)        report("loss_reason", loss_reason, w.reason);
        if (loss_total != w.losses)         report("loss_total", loss_total, w.losses);
        if (noise_total != w.noise)         report("noise_total", noise_total, w.noise);
        if (resync_total != w.resyncs)      report("resync_total", resync_total, w.resyncs);
        if (gap_ratio_q8 != w.ratio)        report("gap_ratio_q8", gap_ratio_q8, w.ratio);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            errors      = 0;
            checked     = 0;
            min_period  = 16'd50;
            max_period  = 32'd100000;
            ratio_lo    = 12'd384;
            ratio_hi    = 12'd896;
            trigger_deg = 9'd0;
            stall_limit = 32'd500000;
            rpm_step    = 16'd1000;
            cooldown    = 32'd100000;
            mode = MODE_LOST;
            since_gap = '0; tooth_idx = '0; bad_cnt = '0; angle = '0; gap_cnt = '0;
            cam_lock = 1'b0; phase = 1'b0; recover_wait = 1'b0; wrap = 1'b0;
            last_edge = '0; period_cur = '0; period_prev = '0; period_avg = '0;
            last_recover = '0; rpm = '0; rpm_avg = '0; ratio = '0; reason = '0;
            loss_cnt = '0; noise_cnt = '0; resync_cnt = '0;
            sync_results_q.delete();
        end else begin
            if (out_valid && !out_stall)
                compare_result();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_PERIOD: min_period  = cfg_data[15:0];
                    CFG_MAX_PERIOD: max_period  = cfg_data;
                    CFG_RATIO_LOW:  ratio_lo    = cfg_data[11:0];
                    CFG_RATIO_HIGH: ratio_hi    = cfg_data[11:0];
                    CFG_TRIGGER:    trigger_deg = cfg_data[8:0];
                    CFG_STALL:      stall_limit = cfg_data;
                    CFG_RPM_STEP:   rpm_step    = cfg_data[15:0];
                    CFG_COOLDOWN:   cooldown    = cfg_data;
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_event(opcode, timestamp_us);
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives wheel, cam and timeout events and reports the verdict.
module tb;
    import mtcs_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 50;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_PHASES    = 5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_NONE;
    logic [31:0] timestamp_us = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  sync_state;
    logic        sync_valid;
    logic [9:0]  crank_angle;
    logic [15:0] engine_rpm, smoothed_rpm;
    logic        compression_phase, cycle_wrapped;
    logic [1:0]  loss_reason;
    logic [15:0] loss_total, noise_total, resync_total, gap_ratio_q8;

    int          errors, pending, checked;
    int          events_sent = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          quiet_from = 0;
    bit          quiet = 1'b0;
    logic [31:0] now_ts;
    logic [15:0] cur_min_period;

    always #5 clk = ~clk;

    missing_tooth_crank_sync_top dut (.*);

    missing_tooth_crank_sync_checker scoreboard (.*);

    // receiver stalls in bursts
    always @(posedge clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_event(logic [1:0] op, logic [31:0] ts);
        if (quiet_from > 0 && events_sent >= quiet_from)
            quiet = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        timestamp_us <= ts;
        do @(posedge clk); while (in_stall);
        events_sent++;
    endtask

    task automatic send_tooth(logic [31:0] dt);
        now_ts = now_ts + dt;
        send_event(OP_TOOTH, now_ts);
    endtask

    // hold the sender until every result is back, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(logic [31:0] vals[8]);
        cfg_valid <= 1'b1;
        for (int i = 0; i < 8; i++) begin
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_min_period = vals[CFG_MIN_PERIOD][15:0];
    endtask

    // revolutions of a 60-2 wheel with occasional cam edges, checks and flaws
    task automatic run_wheel(int limit);
        logic [31:0] period, dt;
        logic [1:0]  op;
        int          revs, pick;
        period = 32'(cur_min_period) + $urandom_range(100, 4000);
        revs   = $urandom_range(2, 5);
        for (int r = 0; r < revs && events_sent < limit; r++) begin
            for (int k = 1; k <= 58 && events_sent < limit; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_event(OP_CAM, $urandom);
                else if (pick < 5)
                    send_event(OP_TIMEOUT, now_ts + $urandom_range(0, 1000));
                else if (pick == 5)
                    send_event(OP_TIMEOUT, now_ts + $urandom);
                else if (pick == 6 && cur_min_period > 0)
                    send_event(OP_TOOTH, now_ts + $urandom_range(0, cur_min_period - 1));
                else if (pick == 7)
                    send_event(OP_NONE, $urandom);
                else if (pick == 8) begin
                    op = 2'($urandom_range(0, 3));
                    dt = $urandom;
                    if (op == OP_TOOTH)
                        now_ts = dt;
                    send_event(op, dt);
                end
                if (k == 58)
                    dt = period * 3;
                else
                    dt = period + $urandom_range(0, period / 16) - period / 32;
                if (pick == 9)
                    dt = dt + period;
                else if (pick == 10)
                    dt = period * 200;
                send_tooth(dt);
            end
        end
    endtask

    initial begin
        logic [31:0] settings[NUM_PHASES][8];
        int          goal;
        settings[0] = '{32'd50, 32'd100000, 32'd384, 32'd896, 32'd0, 32'd500000,
                        32'd1000, 32'd100000};
        settings[1] = '{32'd0, 32'hFFFF_FFFF, 32'd384, 32'd896, 32'd359, 32'hFFFF_FFFF,
                        32'd0, 32'd0};
        settings[2] = '{32'd65535, 32'd0, 32'd0, 32'd4095, 32'd511, 32'd0,
                        32'd65535, 32'hFFFF_FFFF};
        settings[3] = '{32'd20, 32'd200000, 32'd300, 32'd1000, 32'd400, 32'd300000,
                        32'd200, 32'd50000};
        settings[4] = '{32'($urandom_range(10, 200)), 32'($urandom_range(60000, 900000)),
                        32'($urandom_range(320, 640)), 32'($urandom_range(800, 1200)),
                        32'($urandom_range(0, 511)), 32'($urandom_range(100000, 2000000)),
                        32'($urandom_range(50, 3000)), 32'($urandom_range(0, 300000))};
        cur_min_period = 16'd50;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused opcode, cam and timeout while lost, noise, extreme stamps
        send_event(OP_NONE, 32'hFFFF_FFFF);
        send_event(OP_CAM, 32'd0);
        send_event(OP_TIMEOUT, 32'hFFFF_FFFF);
        send_event(OP_TOOTH, 32'd0);
        send_event(OP_TOOTH, 32'd20);
        send_event(OP_TOOTH, 32'd1000);
        send_event(OP_TOOTH, 32'd2000);
        send_event(OP_TOOTH, 32'hFFFF_FFFF);
        send_event(OP_TOOTH, 32'd0);
        send_event(OP_TOOTH, 32'h8000_0000);
        send_event(OP_TOOTH, 32'h8000_0400);
        send_event(OP_TOOTH, 32'h8000_0800);
        send_event(OP_TOOTH, 32'h8000_0C00);
        send_event(OP_CAM, 32'h5555_5555);
        send_event(OP_TIMEOUT, 32'hAAAA_AAAA);
        now_ts = $urandom;
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_regs(settings[p]);
            goal = events_sent + PHASE_ITEMS;
            // no idling on either side over the last stretch of the run
            if (p == NUM_PHASES - 1)
                quiet_from = goal - 90;
            while (events_sent < goal) begin
                run_wheel(goal);
                if (p == 0 && events_sent > goal - PHASE_ITEMS / 2 && pending > 0)
                    drain();
            end
            drain();
        end

        $display("ran %0d events over %0d register settings, %0d results compared",
                 events_sent, NUM_PHASES, checked);
        $display("covered lock, cam phase, stalls, noise, bad gaps and recovery cooldown");
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
